// ----- rtl/dual_format_uart_frame_parser_core_assert.svh -----
// Assertion macros for the frame parser core
`ifndef DUAL_FORMAT_UART_FRAME_PARSER_CORE_ASSERT_SVH
`define DUAL_FORMAT_UART_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFUART_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfuart assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define DFUART_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfuart assertion failed");

`endif

// ----- rtl/dfuart_pkg.sv -----
// Shared types and constants for the dual-format frame parser
`default_nettype none
package dfuart_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam int LEN_W           = 7;

    localparam logic [7:0] SOF_BYTE  = 8'h55;
    localparam logic [7:0] MARK_BYTE = 8'hAA;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5,
        PH_TAIL = 3'd6
    } parse_phase_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_WAIT = 2'd1,
        B_SHOW = 2'd2
    } back_state_t;

    typedef struct packed {
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
        logic             xor_fmt;
    } frame_desc_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic wr_slot;
        logic rd_slot;
    } q_status_t;

endpackage
`default_nettype wire

// ----- rtl/dfuart_ram.sv -----
// Generic single-write, registered-read RAM
`default_nettype none
module dfuart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/dfuart_queue.sv -----
// Two-entry frame descriptor queue; entry index doubles as buffer slot
`default_nettype none
module dfuart_queue
    import dfuart_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire frame_desc_t push_desc,
    input  wire logic        pop,
    output frame_desc_t      head_desc,
    output q_status_t        status
);

    frame_desc_t desc_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            desc_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc      = desc_reg[rd_ptr_reg];
    assign status.empty   = (count_reg == 2'd0);
    assign status.full    = (count_reg == 2'd2);
    assign status.wr_slot = wr_ptr_reg;
    assign status.rd_slot = rd_ptr_reg;

endmodule
`default_nettype wire

// ----- rtl/dfuart_front.sv -----
// Byte parser: frame detection, checksum, payload capture, descriptor push
`default_nettype none
module dfuart_front
    import dfuart_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int IDX_W       = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    input  wire q_status_t          q_status,
    output logic                    push,
    output frame_desc_t             push_desc,
    output logic                    ram_we,
    output logic      [IDX_W:0]     ram_waddr,
    output logic      [7:0]         ram_wdata
);

    parse_phase_t     phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [7:0]       recv_reg, recv_next;
    logic [7:0]       run_reg, run_next;
    logic             xor_reg, xor_next;
    logic             take;

    assign in_ready = !q_status.full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        count_next = count_reg;
        recv_next  = recv_reg;
        run_next   = run_reg;
        xor_next   = xor_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HDR2:
                begin
                    count_next = '0;
                    if (rx_byte == MARK_BYTE)
                    begin
                        xor_next   = 1'b1;
                        phase_next = PH_CMD;
                    end
                    else
                    begin
                        xor_next   = 1'b0;
                        cmd_next   = rx_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    count_next = '0;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    count_next = '0;
                    if (int'(rx_byte) > MAX_PAYLOAD)
                    begin
                        phase_next = PH_WAIT;
                        cmd_next   = '0;
                        len_next   = '0;
                        recv_next  = '0;
                        run_next   = '0;
                        xor_next   = 1'b0;
                    end
                    else
                    begin
                        len_next = LEN_W'(rx_byte);
                        if (xor_reg)
                        begin
                            run_next = SOF_BYTE ^ MARK_BYTE ^ cmd_reg ^ rx_byte;
                        end
                        else
                        begin
                            run_next = cmd_reg + rx_byte;
                        end
                        phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    count_next = count_reg + 1'b1;
                    run_next   = xor_reg ? (run_reg ^ rx_byte) : (run_reg + rx_byte);
                    if ((count_reg + 1'b1) >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    recv_next = rx_byte;
                    if (xor_reg)
                    begin
                        phase_next = PH_WAIT;
                        cmd_next   = '0;
                        len_next   = '0;
                        count_next = '0;
                        recv_next  = '0;
                        run_next   = '0;
                        xor_next   = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    phase_next = PH_WAIT;
                    cmd_next   = '0;
                    len_next   = '0;
                    count_next = '0;
                    recv_next  = '0;
                    run_next   = '0;
                    xor_next   = 1'b0;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                    if (rx_byte == SOF_BYTE)
                    begin
                        phase_next = PH_HDR2;
                        xor_next   = 1'b0;
                        count_next = '0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        push      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {q_status.wr_slot, count_reg[IDX_W-1:0]};
        ram_wdata = rx_byte;
        push_desc.command = cmd_reg;
        push_desc.length  = len_reg;
        push_desc.xor_fmt = xor_reg;
        if (take)
        begin
            case (phase_reg)
                PH_DATA: ram_we = 1'b1;
                PH_SUM:  push   = xor_reg && (rx_byte == run_reg);
                PH_TAIL: push   = (rx_byte == MARK_BYTE) && (recv_reg == run_reg);
                default: push   = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            recv_reg  <= '0;
            run_reg   <= '0;
            xor_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            recv_reg  <= recv_next;
            run_reg   <= run_next;
            xor_reg   <= xor_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/dfuart_back.sv -----
// Frame emitter: reads buffered payload and drives the result word
`default_nettype none
module dfuart_back
    import dfuart_pkg::*;
#(
    parameter int IDX_W = 5
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire q_status_t      q_status,
    input  wire frame_desc_t    head_desc,
    output logic                pop,
    output logic                ram_re,
    output logic      [IDX_W:0] ram_raddr,
    input  wire logic [7:0]     ram_rdata,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic      [7:0]     command,
    output logic      [5:0]     frame_length,
    output logic      [7:0]     payload_byte,
    output logic                payload_valid,
    output logic      [4:0]     byte_position,
    output logic                frame_format,
    output logic                last
);

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             last_reg;
    logic [7:0]       cmd_reg;
    logic [5:0]       len_reg;
    logic [7:0]       byte_reg;
    logic             pv_reg;
    logic [4:0]       pos_reg;
    logic             fmt_reg;
    logic             load_empty;
    logic             load_data;
    logic             data_last;

    assign data_last = ((LEN_W'(k_reg) + 1'b1) == head_desc.length);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = (head_desc.length == '0) ? B_SHOW : B_WAIT;
                end
            end
            B_WAIT:
            begin
                state_next = B_SHOW;
            end
            B_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = last_reg ? B_IDLE : B_WAIT;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = {q_status.rd_slot, k_reg};
        k_next     = k_reg;
        load_empty = 1'b0;
        load_data  = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                k_next = '0;
                if (!q_status.empty)
                begin
                    if (head_desc.length == '0)
                    begin
                        load_empty = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = {q_status.rd_slot, {IDX_W{1'b0}}};
                    end
                end
            end
            B_WAIT:
            begin
                load_data = 1'b1;
            end
            B_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        k_next    = k_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = {q_status.rd_slot, k_next};
                    end
                end
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (load_empty)
            begin
                last_reg <= 1'b1;
            end
            else if (load_data)
            begin
                last_reg <= data_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_empty || load_data)
        begin
            cmd_reg <= head_desc.command;
            len_reg <= 6'(head_desc.length);
            fmt_reg <= head_desc.xor_fmt;
        end
        if (load_empty)
        begin
            byte_reg <= 8'd0;
            pv_reg   <= 1'b0;
            pos_reg  <= 5'd0;
        end
        else if (load_data)
        begin
            byte_reg <= ram_rdata;
            pv_reg   <= 1'b1;
            pos_reg  <= 5'(k_reg);
        end
    end

    assign command       = cmd_reg;
    assign frame_length  = len_reg;
    assign payload_byte  = byte_reg;
    assign payload_valid = pv_reg;
    assign byte_position = pos_reg;
    assign frame_format  = fmt_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

// ----- rtl/dual_format_uart_frame_parser_core.sv -----
// Dual-format serial frame parser: top level
//
// Input channel: in_valid/in_ready with rx_byte, one received byte per word.
// Output channel: out_valid/out_ready with one result word per payload byte
// (command, frame_length, payload_byte, payload_valid, byte_position,
// frame_format, last), or one word with payload_valid low for an empty frame.
// The parser takes one byte per cycle while in_ready is high. A frame that
// passes its check is queued; with the emitter idle, the emitter reads the first
// payload byte and goes through its wait state before out_valid rises (an
// empty frame skips both), and after each taken word it reads the next byte
// and goes through the wait state again, as the payload buffer has a registered read.
// The buffer holds two frames; while two good frames wait to be drained,
// in_ready is low, so a stalled receiver eventually stalls the byte input.
// A dropped frame (oversize length, bad check, bad tail) gives no words.
// Reset (rst_n low, asynchronous) returns the parser to header search and
// empties the frame queue; no output word is pending after reset.
`default_nettype none
`include "dual_format_uart_frame_parser_core_assert.svh"
module dual_format_uart_frame_parser_core
    import dfuart_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] command,
    output logic      [5:0] frame_length,
    output logic      [7:0] payload_byte,
    output logic            payload_valid,
    output logic      [4:0] byte_position,
    output logic            frame_format,
    output logic            last
);

    localparam int IDX_W    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int RamDepth = 2 ** (IDX_W + 1);

    q_status_t      q_status;
    frame_desc_t    push_desc;
    frame_desc_t    head_desc;
    logic           push;
    logic           pop;
    logic           ram_we;
    logic [IDX_W:0] ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [IDX_W:0] ram_raddr;
    logic [7:0]     ram_rdata;

    dfuart_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    dfuart_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    dfuart_ram #(
        .WIDTH (8),
        .DEPTH (RamDepth)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dfuart_back #(
        .IDX_W (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_desc     (head_desc),
        .pop           (pop),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command       (command),
        .frame_length  (frame_length),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .byte_position (byte_position),
        .frame_format  (frame_format),
        .last          (last)
    );

    `DFUART_ASSERT_NOW(a_out_has_frame, out_valid, !q_status.empty)
    `DFUART_ASSERT_NOW(a_empty_word, out_valid && !payload_valid, last && (frame_length == 6'd0))
    `DFUART_ASSERT_NEXT(a_last_pops, out_valid && out_ready && last, !out_valid)

endmodule
`default_nettype wire
